### hdl/bcw_pkg.sv
// Shared types and constants for the barycentric weight pipeline.
package bcw_pkg;

  // Field widths of the channels.
  localparam int COORD_W  = 16;
  localparam int WEIGHT_W = 32;

  // Internal widths of the exact integer arithmetic.
  localparam int DIFF_W  = COORD_W + 1;  // coordinate difference
  localparam int PROD_W  = 2 * DIFF_W;   // one product of differences
  localparam int CROSS_W = PROD_W + 1;   // difference of two products
  localparam int MAG_W   = PROD_W - 1;   // magnitude of a cross product

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_V0_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_V0_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_V1_X = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_V1_Y = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_V2_X = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_V2_Y = 3'd5;

  // Saturation limits of a weight.
  localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = {1'b0, {(WEIGHT_W-1){1'b1}}};
  localparam logic [WEIGHT_W-1:0] WEIGHT_MIN = {1'b1, {(WEIGHT_W-1){1'b0}}};

  // Triangle vertices as held in the configuration registers.
  typedef struct packed {
    logic signed [COORD_W-1:0] x0;
    logic signed [COORD_W-1:0] y0;
    logic signed [COORD_W-1:0] x1;
    logic signed [COORD_W-1:0] y1;
    logic signed [COORD_W-1:0] x2;
    logic signed [COORD_W-1:0] y2;
  } verts_t;

  // Sign and degenerate flags that travel with the quotients.
  typedef struct packed {
    logic neg_g;
    logic neg_b;
    logic degen;
  } side_t;

  // One result item.
  typedef struct packed {
    logic [WEIGHT_W-1:0] alpha;
    logic [WEIGHT_W-1:0] beta;
    logic [WEIGHT_W-1:0] gamma;
    logic                degen;
  } weights_t;

endpackage

### hdl/bcw_ifs.sv
// Channel interfaces for pixel positions and barycentric weights.
interface bcw_pixel_if;
  logic                               valid;
  logic                               ready;
  logic signed [bcw_pkg::COORD_W-1:0] pixel_x;
  logic signed [bcw_pkg::COORD_W-1:0] pixel_y;

  modport source (output valid, pixel_x, pixel_y, input ready);
  modport sink (input valid, pixel_x, pixel_y, output ready);
endinterface

interface bcw_weight_if;
  logic                                valid;
  logic                                ready;
  logic signed [bcw_pkg::WEIGHT_W-1:0] weight_alpha;
  logic signed [bcw_pkg::WEIGHT_W-1:0] weight_beta;
  logic signed [bcw_pkg::WEIGHT_W-1:0] weight_gamma;
  logic                                degenerate;

  modport source (output valid, weight_alpha, weight_beta, weight_gamma, degenerate,
                  input ready);
  modport sink (input valid, weight_alpha, weight_beta, weight_gamma, degenerate,
                output ready);
endinterface

### hdl/triangle_barycentric_weights.sv
// Top level of the barycentric weight pipeline with the vertex registers.
//
//   Channel   Direction  Payload                                    Handshake
//   in_pix    sink       pixel_x, pixel_y (signed Q12.4)            valid/ready
//   out_wgt   source     weight_alpha/beta/gamma (Q15.16), degen.   valid/ready
//   cfg_*     write      cfg_index selects a vertex coordinate      cfg_wr_en
//
// One pixel is taken per cycle while the skid entry is empty. Each pixel passes the
// difference, product, cross product and operand stages, one divider stage per
// quotient bit (33 + WEIGHT_FRAC_BITS), two combine stages and the output register.
// Reset is synchronous and clears the vertex registers and all valid bits.
// A stall holds the whole pipeline once the output skid entry is full; the skid
// entry lets one more result land after the output register stops draining.
module triangle_barycentric_weights #(
  parameter int WEIGHT_FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  bcw_pixel_if.sink                           in_pix,
  bcw_weight_if.source                        out_wgt,
  input  logic                                cfg_wr_en,
  input  logic [bcw_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bcw_pkg::COORD_W-1:0]         cfg_wdata
);

  localparam int MAG_W = bcw_pkg::MAG_W;
  localparam int DVD_W = MAG_W + WEIGHT_FRAC_BITS;

  // Vertex registers; writes beyond the six indexes are dropped.
  bcw_pkg::verts_t verts_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      verts_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        bcw_pkg::REG_V0_X: verts_r.x0 <= cfg_wdata;
        bcw_pkg::REG_V0_Y: verts_r.y0 <= cfg_wdata;
        bcw_pkg::REG_V1_X: verts_r.x1 <= cfg_wdata;
        bcw_pkg::REG_V1_Y: verts_r.y1 <= cfg_wdata;
        bcw_pkg::REG_V2_X: verts_r.x2 <= cfg_wdata;
        bcw_pkg::REG_V2_Y: verts_r.y2 <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic en;
  assign in_pix.ready = en;

  // Cross products and divider operands.
  logic              x_vld;
  bcw_pkg::side_t    x_side;
  logic [MAG_W-1:0]  x_mag_g, x_mag_b, x_mag_a;

  bcw_cross u_cross (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .verts     (verts_r),
    .in_vld    (in_pix.valid),
    .in_px     (in_pix.pixel_x),
    .in_py     (in_pix.pixel_y),
    .out_vld   (x_vld),
    .out_side  (x_side),
    .out_mag_g (x_mag_g),
    .out_mag_b (x_mag_b),
    .out_mag_a (x_mag_a)
  );

  // Quotients of both edge numerators by the area.
  logic              d_vld;
  bcw_pkg::side_t    d_side;
  logic [DVD_W-1:0]  d_q_g, d_q_b;

  bcw_divider #(
    .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
  ) u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (x_vld),
    .in_side  (x_side),
    .in_mag_g (x_mag_g),
    .in_mag_b (x_mag_b),
    .in_mag_a (x_mag_a),
    .out_vld  (d_vld),
    .out_side (d_side),
    .out_q_g  (d_q_g),
    .out_q_b  (d_q_b)
  );

  // Signed weights, alpha and saturation.
  logic              c_vld;
  bcw_pkg::weights_t c_wgt;

  bcw_combine #(
    .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
  ) u_combine (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (d_vld),
    .in_side (d_side),
    .in_q_g  (d_q_g),
    .in_q_b  (d_q_b),
    .out_vld (c_vld),
    .out_wgt (c_wgt)
  );

  // Output register and skid entry.
  bcw_outbuf u_outbuf (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (c_vld),
    .in_wgt  (c_wgt),
    .en      (en),
    .out_wgt (out_wgt)
  );

endmodule

### hdl/bcw_cross.sv
// Edge differences, cross products and operand preparation for the dividers.
module bcw_cross (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  bcw_pkg::verts_t                     verts,
  input  logic                                in_vld,
  input  logic signed [bcw_pkg::COORD_W-1:0]  in_px,
  input  logic signed [bcw_pkg::COORD_W-1:0]  in_py,
  output logic                                out_vld,
  output bcw_pkg::side_t                      out_side,
  output logic        [bcw_pkg::MAG_W-1:0]    out_mag_g,
  output logic        [bcw_pkg::MAG_W-1:0]    out_mag_b,
  output logic        [bcw_pkg::MAG_W-1:0]    out_mag_a
);

  localparam int DIFF_W  = bcw_pkg::DIFF_W;
  localparam int PROD_W  = bcw_pkg::PROD_W;
  localparam int CROSS_W = bcw_pkg::CROSS_W;
  localparam int MAG_W   = bcw_pkg::MAG_W;

  // Stage 1: differences against vertex 0.
  logic                     v1_r;
  logic signed [DIFF_W-1:0] dpx_r, dpy_r, dx1_r, dy1_r, dx2_r, dy2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dpx_r <= DIFF_W'(in_px) - DIFF_W'(verts.x0);
      dpy_r <= DIFF_W'(in_py) - DIFF_W'(verts.y0);
      dx1_r <= DIFF_W'(verts.x1) - DIFF_W'(verts.x0);
      dy1_r <= DIFF_W'(verts.y1) - DIFF_W'(verts.y0);
      dx2_r <= DIFF_W'(verts.x2) - DIFF_W'(verts.x0);
      dy2_r <= DIFF_W'(verts.y2) - DIFF_W'(verts.y0);
    end
  end

  // Stage 2: the six products, one multiplier each.
  logic                     v2_r;
  logic signed [PROD_W-1:0] pgx_r, pgy_r, pbx_r, pby_r, pax_r, pay_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pgx_r <= PROD_W'(dpx_r) * PROD_W'(dy1_r);
      pgy_r <= PROD_W'(dpy_r) * PROD_W'(dx1_r);
      pbx_r <= PROD_W'(dpx_r) * PROD_W'(dy2_r);
      pby_r <= PROD_W'(dpy_r) * PROD_W'(dx2_r);
      pax_r <= PROD_W'(dx2_r) * PROD_W'(dy1_r);
      pay_r <= PROD_W'(dy2_r) * PROD_W'(dx1_r);
    end
  end

  // Stage 3: the edge numerators of gamma and beta and the doubled signed area.
  logic                      v3_r;
  logic signed [CROSS_W-1:0] ng_r, nb_r, area_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ng_r   <= CROSS_W'(pgx_r) - CROSS_W'(pgy_r);
      nb_r   <= CROSS_W'(pbx_r) - CROSS_W'(pby_r);
      area_r <= CROSS_W'(pax_r) - CROSS_W'(pay_r);
    end
  end

  // Stage 4: magnitudes and quotient signs. Beta divides by the negated area.
  logic [CROSS_W-1:0] abs_g, abs_b, abs_a;
  logic               area_zero;

  assign abs_g     = ng_r[CROSS_W-1]   ? -ng_r   : ng_r;
  assign abs_b     = nb_r[CROSS_W-1]   ? -nb_r   : nb_r;
  assign abs_a     = area_r[CROSS_W-1] ? -area_r : area_r;
  assign area_zero = (area_r == '0);

  logic               v4_r;
  bcw_pkg::side_t     side_r;
  logic [MAG_W-1:0]   mag_g_r, mag_b_r, mag_a_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r.neg_g <= ng_r[CROSS_W-1] ^ area_r[CROSS_W-1];
      side_r.neg_b <= nb_r[CROSS_W-1] ^ (!area_r[CROSS_W-1] && !area_zero);
      side_r.degen <= area_zero;
      mag_g_r      <= abs_g[MAG_W-1:0];
      mag_b_r      <= abs_b[MAG_W-1:0];
      mag_a_r      <= abs_a[MAG_W-1:0];
    end
  end

  assign out_vld   = v4_r;
  assign out_side  = side_r;
  assign out_mag_g = mag_g_r;
  assign out_mag_b = mag_b_r;
  assign out_mag_a = mag_a_r;

endmodule

### hdl/bcw_divider.sv
// Pipelined restoring divider, one quotient bit per stage, two lanes on one divisor.
module bcw_divider #(
  parameter int WEIGHT_FRAC_BITS = 16
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         en,
  input  logic                                         in_vld,
  input  bcw_pkg::side_t                               in_side,
  input  logic [bcw_pkg::MAG_W-1:0]                    in_mag_g,
  input  logic [bcw_pkg::MAG_W-1:0]                    in_mag_b,
  input  logic [bcw_pkg::MAG_W-1:0]                    in_mag_a,
  output logic                                         out_vld,
  output bcw_pkg::side_t                               out_side,
  output logic [bcw_pkg::MAG_W+WEIGHT_FRAC_BITS-1:0]   out_q_g,
  output logic [bcw_pkg::MAG_W+WEIGHT_FRAC_BITS-1:0]   out_q_b
);

  localparam int MAG_W = bcw_pkg::MAG_W;
  localparam int DVD_W = MAG_W + WEIGHT_FRAC_BITS;
  localparam int NSTG  = DVD_W;

  // Per-stage registers. Each qd word holds the dividend bits still to be
  // consumed in its upper part and the quotient bits found so far below.
  logic                 vld_r  [1:NSTG];
  bcw_pkg::side_t       side_r [1:NSTG];
  logic [MAG_W-1:0]     div_r  [1:NSTG];
  logic [MAG_W-1:0]     rem_g_r[1:NSTG];
  logic [MAG_W-1:0]     rem_b_r[1:NSTG];
  logic [DVD_W-1:0]     qd_g_r [1:NSTG];
  logic [DVD_W-1:0]     qd_b_r [1:NSTG];

  for (genvar s = 0; s < NSTG; s++) begin : g_stage
    logic               cur_vld;
    bcw_pkg::side_t     cur_side;
    logic [MAG_W-1:0]   cur_div, cur_rem_g, cur_rem_b;
    logic [DVD_W-1:0]   cur_qd_g, cur_qd_b;
    logic [MAG_W:0]     trial_g, trial_b;
    logic [MAG_W+1:0]   diff_g, diff_b;
    logic               ge_g, ge_b;

    // Stage operands: the divider input for the first stage.
    if (s == 0) begin : g_first
      assign cur_vld   = in_vld;
      assign cur_side  = in_side;
      assign cur_div   = in_mag_a;
      assign cur_rem_g = '0;
      assign cur_rem_b = '0;
      assign cur_qd_g  = {in_mag_g, {WEIGHT_FRAC_BITS{1'b0}}};
      assign cur_qd_b  = {in_mag_b, {WEIGHT_FRAC_BITS{1'b0}}};
    end else begin : g_next
      assign cur_vld   = vld_r[s];
      assign cur_side  = side_r[s];
      assign cur_div   = div_r[s];
      assign cur_rem_g = rem_g_r[s];
      assign cur_rem_b = rem_b_r[s];
      assign cur_qd_g  = qd_g_r[s];
      assign cur_qd_b  = qd_b_r[s];
    end

    // Shift in the next dividend bit and try the subtraction.
    assign trial_g = {cur_rem_g, cur_qd_g[DVD_W-1]};
    assign trial_b = {cur_rem_b, cur_qd_b[DVD_W-1]};
    assign diff_g  = {1'b0, trial_g} - {2'b00, cur_div};
    assign diff_b  = {1'b0, trial_b} - {2'b00, cur_div};
    assign ge_g    = !diff_g[MAG_W+1];
    assign ge_b    = !diff_b[MAG_W+1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s+1] <= 1'b0;
      end else if (en) begin
        vld_r[s+1] <= cur_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[s+1]  <= cur_side;
        div_r[s+1]   <= cur_div;
        rem_g_r[s+1] <= ge_g ? diff_g[MAG_W-1:0] : trial_g[MAG_W-1:0];
        rem_b_r[s+1] <= ge_b ? diff_b[MAG_W-1:0] : trial_b[MAG_W-1:0];
        qd_g_r[s+1]  <= {cur_qd_g[DVD_W-2:0], ge_g};
        qd_b_r[s+1]  <= {cur_qd_b[DVD_W-2:0], ge_b};
      end
    end
  end

  // After the last stage the words hold the whole quotients.
  assign out_vld  = vld_r[NSTG];
  assign out_side = side_r[NSTG];
  assign out_q_g  = qd_g_r[NSTG];
  assign out_q_b  = qd_b_r[NSTG];

endmodule

### hdl/bcw_combine.sv
// Signs the quotients, forms alpha and saturates the three weights.
module bcw_combine #(
  parameter int WEIGHT_FRAC_BITS = 16
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         en,
  input  logic                                         in_vld,
  input  bcw_pkg::side_t                               in_side,
  input  logic [bcw_pkg::MAG_W+WEIGHT_FRAC_BITS-1:0]   in_q_g,
  input  logic [bcw_pkg::MAG_W+WEIGHT_FRAC_BITS-1:0]   in_q_b,
  output logic                                         out_vld,
  output bcw_pkg::weights_t                            out_wgt
);

  localparam int WEIGHT_W = bcw_pkg::WEIGHT_W;
  localparam int DVD_W    = bcw_pkg::MAG_W + WEIGHT_FRAC_BITS;
  localparam int SQ_W     = DVD_W + 1;
  localparam int AL_W     = SQ_W + 2;
  localparam logic signed [AL_W-1:0] ONE = AL_W'(1) << WEIGHT_FRAC_BITS;

  // Clamp a wide signed value into the weight range.
  function automatic logic [WEIGHT_W-1:0] sat_weight(input logic signed [AL_W-1:0] v);
    logic [AL_W-WEIGHT_W:0] top;
    top = v[AL_W-1:WEIGHT_W-1];
    if ((&top) || !(|top)) begin
      sat_weight = v[WEIGHT_W-1:0];
    end else if (v[AL_W-1]) begin
      sat_weight = bcw_pkg::WEIGHT_MIN;
    end else begin
      sat_weight = bcw_pkg::WEIGHT_MAX;
    end
  endfunction

  // Stage 1: apply the quotient signs.
  logic signed [SQ_W-1:0] qe_g, qe_b;
  assign qe_g = $signed({1'b0, in_q_g});
  assign qe_b = $signed({1'b0, in_q_b});

  logic                   v1_r;
  logic                   degen1_r;
  logic signed [SQ_W-1:0] g1_r, b1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      degen1_r <= in_side.degen;
      g1_r     <= in_side.neg_g ? -qe_g : qe_g;
      b1_r     <= in_side.neg_b ? -qe_b : qe_b;
    end
  end

  // Stage 2: alpha from the unsaturated beta and gamma.
  logic                   v2_r;
  logic                   degen2_r;
  logic signed [AL_W-1:0] a2_r, b2_r, g2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      degen2_r <= degen1_r;
      a2_r     <= ONE - AL_W'(b1_r) - AL_W'(g1_r);
      b2_r     <= AL_W'(b1_r);
      g2_r     <= AL_W'(g1_r);
    end
  end

  // Saturation; a zero-area triangle gives zero weights.
  always_comb begin
    out_wgt.degen = degen2_r;
    if (degen2_r) begin
      out_wgt.alpha = '0;
      out_wgt.beta  = '0;
      out_wgt.gamma = '0;
    end else begin
      out_wgt.alpha = sat_weight(a2_r);
      out_wgt.beta  = sat_weight(b2_r);
      out_wgt.gamma = sat_weight(g2_r);
    end
  end

  assign out_vld = v2_r;

endmodule

### hdl/bcw_outbuf.sv
// Output register with one skid entry; its registered ready advances the pipeline.
module bcw_outbuf (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_vld,
  input  bcw_pkg::weights_t    in_wgt,
  output logic                 en,
  bcw_weight_if.source         out_wgt
);

  logic              out_vld_r;
  bcw_pkg::weights_t out_data_r;
  logic              skid_vld_r;
  bcw_pkg::weights_t skid_data_r;
  logic              in_take;
  logic              out_free;

  // The pipeline moves whenever the skid entry is empty.
  assign en       = !skid_vld_r;
  assign in_take  = in_vld && en;
  assign out_free = !out_vld_r || out_wgt.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r  <= skid_vld_r || in_take;
      skid_vld_r <= 1'b0;
    end else if (in_take) begin
      skid_vld_r <= 1'b1;
    end
  end

  // Payload: the skid entry drains first, else the new item goes straight out.
  always_ff @(posedge clk) begin
    if (out_free) begin
      out_data_r <= skid_vld_r ? skid_data_r : in_wgt;
    end else if (in_take) begin
      skid_data_r <= in_wgt;
    end
  end

  assign out_wgt.valid        = out_vld_r;
  assign out_wgt.weight_alpha = out_data_r.alpha;
  assign out_wgt.weight_beta  = out_data_r.beta;
  assign out_wgt.weight_gamma = out_data_r.gamma;
  assign out_wgt.degenerate   = out_data_r.degen;

endmodule

### verif/triangle_barycentric_weights_tb.sv
// Testbench for the barycentric weight block: directed and random triangles against a predictor.
module triangle_barycentric_weights_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WEIGHT_FRAC_BITS = 16;
  localparam int LATENCY = 40 + WEIGHT_FRAC_BITS;
  localparam longint ONE_WEIGHT = longint'(1) << WEIGHT_FRAC_BITS;
  localparam int RANDOM_PIXELS = 1650;
  localparam int COORD_W = bcw_pkg::COORD_W;
  localparam int WEIGHT_W = bcw_pkg::WEIGHT_W;
  localparam int CFG_IDX_W = bcw_pkg::CFG_IDX_W;
  localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = bcw_pkg::WEIGHT_MAX;
  localparam logic [WEIGHT_W-1:0] WEIGHT_MIN = bcw_pkg::WEIGHT_MIN;

  // Indexes past the last vertex register; writes to them must be dropped.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

  typedef enum {STALL_NONE, STALL_RANDOM, STALL_PERIODIC, STALL_LONG} stall_mode_e;
  typedef enum {TRI_WIDE, TRI_SMALL, TRI_TINY, TRI_COLLINEAR, TRI_CORNERS} tri_style_e;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [COORD_W-1:0]   cfg_wdata;

  bcw_pixel_if  in_pix ();
  bcw_weight_if out_wgt ();

  triangle_barycentric_weights #(
    .WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_pix    (in_pix),
    .out_wgt   (out_wgt),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Predictor's copy of the vertex registers and the weights still owed.
  bcw_pkg::verts_t   tri_verts;
  bcw_pkg::weights_t expected_weights[$];

  int error_count = 0;
  int pixel_count = 0;
  int result_count = 0;
  int degenerate_count = 0;
  int saturated_count = 0;
  int triangle_count = 0;
  int burst_left = 0;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Run limit, far above the slowest legal run.
  initial begin
    #5_000_000;
    $display("Timeout with %0d weight results still owed", expected_weights.size());
    $display("DONE: errors detected");
    $finish;
  end

  // Clamp to the 16-bit signed coordinate range.
  function automatic int clamp_coord(input int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic int rand_between(input int lo, input int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  function automatic logic [WEIGHT_W-1:0] sat_weight(input longint v);
    if (v > longint'($signed(WEIGHT_MAX))) return WEIGHT_MAX;
    if (v < longint'($signed(WEIGHT_MIN))) return WEIGHT_MIN;
    return v[WEIGHT_W-1:0];
  endfunction

  // Weights of one pixel against the current triangle, truncated toward zero.
  function automatic bcw_pkg::weights_t predict_weights(
    input logic signed [COORD_W-1:0] px,
    input logic signed [COORD_W-1:0] py);
    longint            dx1, dy1, dx2, dy2, dpx, dpy, area2, q_gamma, q_beta;
    bcw_pkg::weights_t w;
    dx1 = longint'($signed(tri_verts.x1)) - longint'($signed(tri_verts.x0));
    dy1 = longint'($signed(tri_verts.y1)) - longint'($signed(tri_verts.y0));
    dx2 = longint'($signed(tri_verts.x2)) - longint'($signed(tri_verts.x0));
    dy2 = longint'($signed(tri_verts.y2)) - longint'($signed(tri_verts.y0));
    dpx = longint'(px) - longint'($signed(tri_verts.x0));
    dpy = longint'(py) - longint'($signed(tri_verts.y0));
    area2 = dx2 * dy1 - dy2 * dx1;
    w = '0;
    if (area2 == 0) begin
      w.degen = 1'b1;
      return w;
    end
    q_gamma = ((dpx * dy1 - dpy * dx1) * ONE_WEIGHT) / area2;
    q_beta  = ((dpx * dy2 - dpy * dx2) * ONE_WEIGHT) / (-area2);
    w.alpha = sat_weight(ONE_WEIGHT - q_beta - q_gamma);
    w.beta  = sat_weight(q_beta);
    w.gamma = sat_weight(q_gamma);
    return w;
  endfunction

  task automatic report_mismatch(input string what, input logic [WEIGHT_W-1:0] got,
                                 input logic [WEIGHT_W-1:0] want);
    $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    error_count++;
  endtask

  // Result checker: each transfer on the weight channel against the oldest expectation.
  always @(posedge clk) begin
    bcw_pkg::weights_t want;
    if (rst_n && out_wgt.valid && out_wgt.ready) begin
      if (expected_weights.size() == 0) begin
        report_mismatch("unexpected result", out_wgt.weight_alpha, '0);
      end else begin
        want = expected_weights.pop_front();
        result_count++;
        if (want.degen) degenerate_count++;
        if (want.alpha inside {WEIGHT_MAX, WEIGHT_MIN} || want.beta inside {WEIGHT_MAX, WEIGHT_MIN}
            || want.gamma inside {WEIGHT_MAX, WEIGHT_MIN})
          saturated_count++;
        if (out_wgt.weight_alpha !== want.alpha)
          report_mismatch("weight_alpha", out_wgt.weight_alpha, want.alpha);
        if (out_wgt.weight_beta !== want.beta)
          report_mismatch("weight_beta", out_wgt.weight_beta, want.beta);
        if (out_wgt.weight_gamma !== want.gamma)
          report_mismatch("weight_gamma", out_wgt.weight_gamma, want.gamma);
        if (out_wgt.degenerate !== want.degen)
          report_mismatch("degenerate", WEIGHT_W'(out_wgt.degenerate), WEIGHT_W'(want.degen));
      end
    end
  end

  // Receiver backpressure: a stall pattern chosen anew whenever its random span runs out.
  initial begin
    stall_mode_e mode;
    int          span;
    int          phase;
    span = 0;
    phase = 0;
    mode = STALL_NONE;
    out_wgt.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (span == 0) begin
        mode = stall_mode_e'($urandom_range(0, 3));
        span = $urandom_range(50, 300);
        phase = 0;
      end
      span--;
      phase++;
      case (mode)
        STALL_NONE:     out_wgt.ready <= 1'b1;
        STALL_RANDOM:   out_wgt.ready <= ($urandom_range(0, 1) == 1);
        STALL_PERIODIC: out_wgt.ready <= ((phase % 5) < 3);
        default:        out_wgt.ready <= ((phase % 24) < 8);
      endcase
    end
  end

  // One register write, taken at the next edge; the caller lowers the enable.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COORD_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      bcw_pkg::REG_V0_X: tri_verts.x0 = data;
      bcw_pkg::REG_V0_Y: tri_verts.y0 = data;
      bcw_pkg::REG_V1_X: tri_verts.x1 = data;
      bcw_pkg::REG_V1_Y: tri_verts.y1 = data;
      bcw_pkg::REG_V2_X: tri_verts.x2 = data;
      bcw_pkg::REG_V2_Y: tri_verts.y2 = data;
      default: ;
    endcase
  endtask

  task automatic set_triangle(input int x0, input int y0, input int x1, input int y1,
                              input int x2, input int y2);
    write_reg(bcw_pkg::REG_V0_X, COORD_W'(clamp_coord(x0)));
    write_reg(bcw_pkg::REG_V0_Y, COORD_W'(clamp_coord(y0)));
    write_reg(bcw_pkg::REG_V1_X, COORD_W'(clamp_coord(x1)));
    write_reg(bcw_pkg::REG_V1_Y, COORD_W'(clamp_coord(y1)));
    write_reg(bcw_pkg::REG_V2_X, COORD_W'(clamp_coord(x2)));
    write_reg(bcw_pkg::REG_V2_Y, COORD_W'(clamp_coord(y2)));
    cfg_wr_en <= 1'b0;
    triangle_count++;
  endtask

  // Send one pixel in bursts with random gaps; the expectation is queued on transfer.
  task automatic send_pixel(input int px, input int py);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 7);
      if (gap != 0) begin
        in_pix.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_pix.valid   <= 1'b1;
    in_pix.pixel_x <= COORD_W'(px);
    in_pix.pixel_y <= COORD_W'(py);
    @(posedge clk);
    while (!in_pix.ready) @(posedge clk);
    burst_left--;
    pixel_count++;
    expected_weights.push_back(predict_weights(COORD_W'(px), COORD_W'(py)));
  endtask

  // Stop sending and wait until every owed result has come back.
  task automatic drain_results();
    in_pix.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (expected_weights.size() != 0);
  endtask

  // Registers after reset hold a zero-area triangle.
  task automatic test_reset_state();
    send_pixel(0, 0);
    send_pixel(32767, -32768);
    send_pixel(-32768, 32767);
  endtask

  // Right triangle 16 pixels on a side, clockwise in screen space.
  task automatic test_unit_triangle();
    drain_results();
    set_triangle(0, 0, 256, 0, 0, 256);
    send_pixel(0, 0);
    send_pixel(256, 0);
    send_pixel(0, 256);
    send_pixel(85, 85);
    send_pixel(-512, 1000);
  endtask

  // Same triangle with the opposite winding gives a positive area.
  task automatic test_winding();
    drain_results();
    set_triangle(0, 0, 0, 256, 256, 0);
    send_pixel(64, 32);
    send_pixel(300, -20);
  endtask

  // Writes past the last vertex register must leave the triangle alone.
  task automatic test_ignored_index();
    drain_results();
    write_reg(REG_UNUSED_LO, 16'h1234);
    write_reg(REG_UNUSED_HI, 16'h8000);
    cfg_wr_en <= 1'b0;
    send_pixel(64, 64);
    send_pixel(128, 0);
  endtask

  // Triangle of doubled area one in one corner with pixels in the far corners saturates.
  task automatic test_saturation();
    drain_results();
    set_triangle(32767, 32767, 32766, 32767, 32767, 32766);
    send_pixel(-32768, -32768);
    send_pixel(32767, -32768);
    send_pixel(-32768, 32767);
    send_pixel(32767, 32767);
  endtask

  // Vertices at the coordinate extremes give the largest area.
  task automatic test_extreme_vertices();
    drain_results();
    set_triangle(-32768, -32768, 32767, -32768, -32768, 32767);
    send_pixel(0, 0);
    send_pixel(32767, 32767);
    send_pixel(-32768, -32768);
  endtask

  // Three distinct collinear vertices have zero area.
  task automatic test_collinear();
    drain_results();
    set_triangle(-1000, -500, 0, 0, 2000, 1000);
    send_pixel(0, 0);
    send_pixel(32767, -32768);
  endtask

  function automatic int pick_extreme();
    case ($urandom_range(0, 4))
      0: return -32768;
      1: return 32767;
      2: return 0;
      3: return -1;
      default: return rand_between(-32768, 32767);
    endcase
  endfunction

  // New random triangle of a random style.
  task automatic pick_random_triangle();
    tri_style_e style;
    int         v[6];
    int         cx, cy, dx, dy, k;
    style = tri_style_e'($urandom_range(0, 4));
    case (style)
      TRI_WIDE: begin
        foreach (v[i]) v[i] = rand_between(-32768, 32767);
      end
      TRI_SMALL: begin
        cx = rand_between(-30000, 30000);
        cy = rand_between(-30000, 30000);
        foreach (v[i]) v[i] = ((i % 2) == 0 ? cx : cy) + rand_between(-64, 64);
      end
      TRI_TINY: begin
        cx = rand_between(-32000, 32000);
        cy = rand_between(-32000, 32000);
        foreach (v[i]) v[i] = ((i % 2) == 0 ? cx : cy) + rand_between(-2, 2);
      end
      TRI_COLLINEAR: begin
        cx = rand_between(-16000, 16000);
        cy = rand_between(-16000, 16000);
        dx = rand_between(-256, 256);
        dy = rand_between(-256, 256);
        k = rand_between(0, 3);
        v = '{cx, cy, cx + dx, cy + dy, cx - k * dx, cy - k * dy};
      end
      default: begin
        foreach (v[i]) v[i] = pick_extreme();
      end
    endcase
    set_triangle(v[0], v[1], v[2], v[3], v[4], v[5]);
  endtask

  // Pixel near the triangle's bounding box, or anywhere.
  task automatic send_random_pixel();
    int xs[3], ys[3];
    int px, py;
    if ($urandom_range(0, 99) < 35) begin
      px = rand_between(-32768, 32767);
      py = rand_between(-32768, 32767);
    end else begin
      xs = '{$signed(tri_verts.x0), $signed(tri_verts.x1), $signed(tri_verts.x2)};
      ys = '{$signed(tri_verts.y0), $signed(tri_verts.y1), $signed(tri_verts.y2)};
      xs.sort();
      ys.sort();
      px = clamp_coord(rand_between(xs[0] - 32, xs[2] + 32));
      py = clamp_coord(rand_between(ys[0] - 32, ys[2] + 32));
    end
    send_pixel(px, py);
  endtask

  task automatic test_random_triangles();
    int pixels_done;
    int n;
    pixels_done = 0;
    while (pixels_done < RANDOM_PIXELS) begin
      drain_results();
      pick_random_triangle();
      n = $urandom_range(20, 80);
      repeat (n) send_random_pixel();
      pixels_done += n;
    end
  endtask

  // Test sequence.
  initial begin
    tri_verts = '0;
    rst_n          <= 1'b0;
    cfg_wr_en      <= 1'b0;
    cfg_index      <= '0;
    cfg_wdata      <= '0;
    in_pix.valid   <= 1'b0;
    in_pix.pixel_x <= '0;
    in_pix.pixel_y <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_unit_triangle();
    test_winding();
    test_ignored_index();
    test_saturation();
    test_extreme_vertices();
    test_collinear();
    test_random_triangles();

    drain_results();
    repeat (2 * LATENCY) @(posedge clk);

    $display("Checked %0d weight results from %0d pixel transfers over %0d triangles.",
             result_count, pixel_count, triangle_count);
    $display("%0d degenerate results, %0d with a saturated weight, %0d mismatches.",
             degenerate_count, saturated_count, error_count);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
